// ===== rtl/nsp_pkg.sv =====
// Package for the numbered suffix parser: beat and result types,
// ASCII codes and the fixed limits of the suffix rule.
// No dependencies; every other file of the block imports it.
`timescale 1ns / 1ps

package nsp_pkg;

    // Field widths
    localparam int BYTE_W   = 8;
    localparam int BASE_W   = 11;
    localparam int SERIAL_W = 32;
    localparam int RUN_W    = 4;
    localparam int DIGIT_W  = 4;
    // Accumulator holds values up to 2^32 (the saturation mark)
    localparam int VAL_W    = SERIAL_W + 1;
    // Width of value * 10 + digit before the saturation check
    localparam int PROD_W   = VAL_W + 4;

    // ASCII codes
    localparam logic [BYTE_W-1:0] CHAR_UNDERSCORE = 8'h5F;
    localparam logic [BYTE_W-1:0] CHAR_ZERO       = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE       = 8'h39;

    // Suffix rule limits
    localparam logic [RUN_W-1:0] RUN_CAP    = 4'd11;
    localparam logic [RUN_W-1:0] MAX_DIGITS = 4'd10;
    localparam int               MIN_NAME   = 3;

    localparam logic [VAL_W-1:0]  VALUE_LIMIT = 33'h0_FFFF_FFFF;
    localparam logic [VAL_W-1:0]  VALUE_SAT   = 33'h1_0000_0000;

    // One byte of the name
    typedef struct packed {
        logic [BYTE_W-1:0] name_byte;
        logic              is_last;
    } beat_t;

    // One parse result
    typedef struct packed {
        logic [BASE_W-1:0]   base_length;
        logic [SERIAL_W-1:0] serial_number;
    } result_t;

endpackage

// ===== rtl/nsp_byte_if.sv =====
// Channel interfaces of the numbered suffix parser: the name byte stream
// and the result stream, each a valid/ready pair with its payload.
// Depends on nsp_pkg.
`timescale 1ns / 1ps

interface nsp_byte_if import nsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] name_byte;
    logic              is_last;

    modport source (output valid, name_byte, is_last, input ready);
    modport sink   (input valid, name_byte, is_last, output ready);
endinterface

interface nsp_result_if import nsp_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [BASE_W-1:0]   base_length;
    logic [SERIAL_W-1:0] serial_number;

    modport source (output valid, base_length, serial_number, input ready);
    modport sink   (input valid, base_length, serial_number, output ready);
endinterface

// ===== rtl/numbered_suffix_parser.sv =====
// Numbered suffix parser: finds a trailing "_N" serial suffix in a name.
//
// Channels: name_stream carries one byte of the name per beat, with
// is_last on the final byte. results carries one beat per name:
// base_length (length without the accepted "_N") and serial_number
// (the value N, or 0 with the full length when no suffix is accepted).
// A suffix needs a name of at least 3 bytes, an underscore followed by
// 1 to 10 digits up to the end, no leading zero, N nonzero and N < 2^32.
// Names longer than MAX_LEN count as MAX_LEN bytes.
// Throughput: one byte per cycle unless a full skid stage holds a last byte,
// with a combinational parse step between the input and result registers.
// Path: a last byte waits in the input register, is parsed combinationally,
// and its result is registered in the result register or the skid stage.
// Reset clears the parse state and empties the input, result and skid registers.
// When the receiver stalls, a skid stage holds one extra result; after
// that a last byte waits in the input register and the byte stream
// stalls until results drains.
// Depends on nsp_pkg, nsp_byte_if, nsp_in_reg, nsp_core, nsp_out_skid.
`timescale 1ns / 1ps

module numbered_suffix_parser import nsp_pkg::*;
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    nsp_byte_if.sink     name_stream,
    nsp_result_if.source results
);

    logic    beat_valid;
    beat_t   beat;
    logic    advance;
    logic    res_valid;
    result_t res;
    logic    res_ready;

    // Input register
    nsp_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .name_stream (name_stream),
        .advance     (advance),
        .beat_valid  (beat_valid),
        .beat        (beat)
    );

    // Parse state and suffix decision
    nsp_core #(
        .MAX_LEN (MAX_LEN)
    ) u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .beat_valid (beat_valid),
        .beat       (beat),
        .advance    (advance),
        .res_valid  (res_valid),
        .res        (res),
        .res_ready  (res_ready)
    );

    // Result register and skid stage
    nsp_out_skid u_out_skid (
        .clk       (clk),
        .rst_n     (rst_n),
        .res_valid (res_valid),
        .res       (res),
        .res_ready (res_ready),
        .results   (results)
    );

    // A result is only produced when the skid stage has room
    assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> res_ready)
        else $error("result produced while skid stage full");

    // The skid stage only fills behind a held result beat
    assert property (@(posedge clk) disable iff (!rst_n)
        !res_ready |-> results.valid)
        else $error("skid stage full with result register empty");

    // The byte path only stalls on a last byte blocked by a full skid
    assert property (@(posedge clk) disable iff (!rst_n)
        (beat_valid && !advance) |-> (beat.is_last && !res_ready))
        else $error("byte beat stalled without back-pressure");

    // The result register holds a beat in the cycle after a last byte left the input register
    assert property (@(posedge clk) disable iff (!rst_n)
        (advance && beat.is_last) |=> results.valid)
        else $error("result beat missing after last byte");

endmodule

// ===== rtl/nsp_in_reg.sv =====
// Input register of the numbered suffix parser: holds one byte beat for
// the parse logic and refills in the cycle the held beat is consumed.
// Depends on nsp_pkg and nsp_byte_if.
`timescale 1ns / 1ps

module nsp_in_reg import nsp_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    nsp_byte_if.sink    name_stream,
    input  logic        advance,
    output logic        beat_valid,
    output beat_t       beat
);

    logic  valid_reg;
    logic  valid_next;
    beat_t beat_reg;
    logic  load;

    // Free when empty or when the held beat leaves this cycle
    assign name_stream.ready = !valid_reg || advance;
    assign load              = name_stream.valid && name_stream.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            beat_reg.name_byte <= name_stream.name_byte;
            beat_reg.is_last   <= name_stream.is_last;
        end
    end

    assign beat_valid = valid_reg;
    assign beat       = beat_reg;

endmodule

// ===== rtl/nsp_core.sv =====
// Parse logic of the numbered suffix parser: per-name state (byte count,
// digit run, saturating accumulator, flags) and the suffix decision.
// Depends on nsp_pkg.
`timescale 1ns / 1ps

module nsp_core import nsp_pkg::*;
#(
    parameter int MAX_LEN = 1024
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    beat_valid,
    input  beat_t   beat,
    output logic    advance,
    output logic    res_valid,
    output result_t res,
    input  logic    res_ready
);

    localparam int CNT_W = $clog2(MAX_LEN + 1);
    localparam int CMP_W = ((CNT_W > RUN_W) ? CNT_W : RUN_W) + 1;
    localparam int EXT_W = (CMP_W > BASE_W) ? CMP_W : BASE_W;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LEN);

    logic [CNT_W-1:0]  count_reg,    count_next;
    logic [RUN_W-1:0]  run_len_reg,  run_len_next;
    logic [VAL_W-1:0]  run_val_reg,  run_val_next;
    logic              after_us_reg, after_us_next;
    logic              lead_zero_reg, lead_zero_next;
    logic              prev_us_reg,  prev_us_next;

    // Updated state before the end-of-name clear
    logic [CNT_W-1:0]  cnt_upd;
    logic [RUN_W-1:0]  run_upd;
    logic [VAL_W-1:0]  val_upd;
    logic              after_us_upd;
    logic              lead_zero_upd;
    logic              is_digit;
    logic [DIGIT_W-1:0] digit;
    logic [PROD_W-1:0] prod;
    logic [EXT_W-1:0]  cnt_ext;
    logic [EXT_W-1:0]  run_ext;
    logic [EXT_W-1:0]  base_ext;
    logic              accept;

    // A last byte may only move on when the result side has room
    assign advance   = beat_valid && (!beat.is_last || res_ready);
    assign res_valid = advance && beat.is_last;

    // Digit run and accumulator update
    always_comb
    begin
        is_digit = beat.name_byte inside {[CHAR_ZERO:CHAR_NINE]};
        digit    = DIGIT_W'(beat.name_byte - CHAR_ZERO);
        // value * 10 + digit as two shifted adds
        prod     = (PROD_W'(run_val_reg) << 3) + (PROD_W'(run_val_reg) << 1)
                 + PROD_W'(digit);

        run_upd       = run_len_reg;
        val_upd       = run_val_reg;
        after_us_upd  = after_us_reg;
        lead_zero_upd = lead_zero_reg;
        if (is_digit)
        begin
            if (run_len_reg == '0)
            begin
                run_upd       = RUN_W'(1);
                after_us_upd  = prev_us_reg;
                lead_zero_upd = (digit == '0);
                val_upd       = VAL_W'(digit);
            end
            else
            begin
                if (run_len_reg < RUN_CAP)
                begin
                    run_upd = run_len_reg + RUN_W'(1);
                end
                if (run_val_reg > VALUE_LIMIT)
                begin
                    val_upd = VALUE_SAT;
                end
                else if (prod > PROD_W'(VALUE_LIMIT))
                begin
                    val_upd = VALUE_SAT;
                end
                else
                begin
                    val_upd = prod[VAL_W-1:0];
                end
            end
        end
        else
        begin
            run_upd       = '0;
            val_upd       = '0;
            after_us_upd  = 1'b0;
            lead_zero_upd = 1'b0;
        end

        // Byte count saturates at the maximum name length
        cnt_upd = (count_reg < MAX_CNT) ? count_reg + CNT_W'(1) : count_reg;
    end

    // Suffix decision on the updated state
    always_comb
    begin
        cnt_ext  = EXT_W'(cnt_upd);
        run_ext  = EXT_W'(run_upd);
        base_ext = cnt_ext - run_ext - EXT_W'(1);
        accept   = (cnt_ext >= EXT_W'(MIN_NAME))
                && (run_upd != '0)
                && (run_upd <= MAX_DIGITS)
                && after_us_upd
                && !lead_zero_upd
                && (val_upd != '0)
                && (val_upd <= VALUE_LIMIT)
                && (cnt_ext >= run_ext + EXT_W'(1));

        if (accept)
        begin
            res.base_length   = base_ext[BASE_W-1:0];
            res.serial_number = val_upd[SERIAL_W-1:0];
        end
        else
        begin
            res.base_length   = cnt_ext[BASE_W-1:0];
            res.serial_number = '0;
        end
    end

    // Next state: hold, update, or clear after the last byte
    always_comb
    begin
        count_next     = count_reg;
        run_len_next   = run_len_reg;
        run_val_next   = run_val_reg;
        after_us_next  = after_us_reg;
        lead_zero_next = lead_zero_reg;
        prev_us_next   = prev_us_reg;
        if (advance)
        begin
            if (beat.is_last)
            begin
                count_next     = '0;
                run_len_next   = '0;
                run_val_next   = '0;
                after_us_next  = 1'b0;
                lead_zero_next = 1'b0;
                prev_us_next   = 1'b0;
            end
            else
            begin
                count_next     = cnt_upd;
                run_len_next   = run_upd;
                run_val_next   = val_upd;
                after_us_next  = after_us_upd;
                lead_zero_next = lead_zero_upd;
                prev_us_next   = (beat.name_byte == CHAR_UNDERSCORE);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            run_len_reg   <= '0;
            run_val_reg   <= '0;
            after_us_reg  <= 1'b0;
            lead_zero_reg <= 1'b0;
            prev_us_reg   <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            run_len_reg   <= run_len_next;
            run_val_reg   <= run_val_next;
            after_us_reg  <= after_us_next;
            lead_zero_reg <= lead_zero_next;
            prev_us_reg   <= prev_us_next;
        end
    end

endmodule

// ===== rtl/nsp_out_skid.sv =====
// Result register with a skid stage for the numbered suffix parser;
// its ready toward the parse logic comes straight from a register.
// Depends on nsp_pkg and nsp_result_if.
`timescale 1ns / 1ps

module nsp_out_skid import nsp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          res_valid,
    input  result_t       res,
    output logic          res_ready,
    nsp_result_if.source  results
);

    logic    main_valid_reg, main_valid_next;
    logic    skid_valid_reg, skid_valid_next;
    result_t main_reg,       main_next;
    result_t skid_reg,       skid_next;
    logic    push;
    logic    main_free;

    assign res_ready = !skid_valid_reg;
    assign push      = res_valid && res_ready;
    assign main_free = !main_valid_reg || results.ready;

    // Main register refills from the skid first, then from the parser
    always_comb
    begin
        main_valid_next = main_valid_reg;
        skid_valid_next = skid_valid_reg;
        main_next       = main_reg;
        skid_next       = skid_reg;
        if (main_free)
        begin
            if (skid_valid_reg)
            begin
                main_next       = skid_reg;
                main_valid_next = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (push)
            begin
                main_next       = res;
                main_valid_next = 1'b1;
            end
            else
            begin
                main_valid_next = 1'b0;
            end
        end
        else if (push)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_valid_reg <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            main_valid_reg <= main_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        main_reg <= main_next;
        skid_reg <= skid_next;
    end

    assign results.valid         = main_valid_reg;
    assign results.base_length   = main_reg.base_length;
    assign results.serial_number = main_reg.serial_number;

endmodule

// ===== test/numbered_suffix_parser_tb.sv =====
// Testbench for numbered_suffix_parser: streams names one beat per byte and
// checks every result beat against a local suffix predictor.
// Depends on nsp_pkg, nsp_byte_if / nsp_result_if and the parser RTL.
`timescale 1ns / 1ps

module numbered_suffix_parser_tb;
    import nsp_pkg::*;

    localparam int NAME_MAX_LEN = 1024;
    localparam int STALL_PCT    = 35;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    nsp_byte_if   name_stream_if ();
    nsp_result_if results_if ();

    numbered_suffix_parser #(
        .MAX_LEN (NAME_MAX_LEN)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .name_stream (name_stream_if),
        .results     (results_if)
    );

    // Predictor state for the name being parsed
    int unsigned       seen_bytes;
    logic [RUN_W-1:0]  digit_run;
    logic [63:0]       run_val;
    logic              run_after_underscore;
    logic              run_leading_zero;
    logic              last_was_underscore;

    // Parses still owed by the block, oldest first
    result_t           awaited_parses[$];
    // Name being assembled for sending
    logic [BYTE_W-1:0] name_buf[$];

    bit stall_on       = 1'b1;
    int error_count    = 0;
    int names_sent     = 0;
    int bytes_sent     = 0;
    int suffixes_found = 0;

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function void clear_parse();
        seen_bytes           = 0;
        digit_run            = '0;
        run_val              = '0;
        run_after_underscore = 1'b0;
        run_leading_zero     = 1'b0;
        last_was_underscore  = 1'b0;
    endfunction

    // Advance the suffix predictor by one accepted byte; queue a parse on the last one
    function void parse_name_byte(input logic [BYTE_W-1:0] ch, input logic last);
        logic [63:0] digit;
        logic [63:0] next_val;
        int unsigned base;
        bit          accepted;
        result_t     parsed;
        digit = {56'd0, ch - CHAR_ZERO};
        if (ch >= CHAR_ZERO && ch <= CHAR_NINE)
        begin
            if (digit_run == 0)
            begin
                digit_run            = RUN_W'(1);
                run_after_underscore = last_was_underscore;
                run_leading_zero     = (digit == 0);
                run_val              = digit;
            end
            else
            begin
                if (digit_run < RUN_CAP)
                    digit_run = digit_run + RUN_W'(1);
                // sticky saturation once past 32 bits
                if (run_val > VALUE_LIMIT)
                    run_val = VALUE_SAT;
                else
                begin
                    next_val = run_val * 10 + digit;
                    run_val  = (next_val > VALUE_LIMIT) ? VALUE_SAT : next_val;
                end
            end
        end
        else
        begin
            digit_run            = '0;
            run_val              = '0;
            run_after_underscore = 1'b0;
            run_leading_zero     = 1'b0;
        end
        last_was_underscore = (ch == CHAR_UNDERSCORE);
        if (seen_bytes < NAME_MAX_LEN)
            seen_bytes++;

        if (last)
        begin
            accepted = seen_bytes >= MIN_NAME && digit_run >= 1 && digit_run <= MAX_DIGITS
                && run_after_underscore && !run_leading_zero && run_val != 0
                && run_val <= VALUE_LIMIT && seen_bytes >= digit_run + 1;
            base = seen_bytes;
            parsed.serial_number = '0;
            if (accepted)
            begin
                base                 = seen_bytes - digit_run - 1;
                parsed.serial_number = run_val[SERIAL_W-1:0];
                suffixes_found++;
            end
            parsed.base_length = base[BASE_W-1:0];
            awaited_parses.push_back(parsed);
            clear_parse();
        end
    endfunction

    // Result side: random back-pressure and in-order field check
    always @(posedge clk)
    begin
        if (!rst_n)
            results_if.ready <= 1'b0;
        else
        begin
            if (results_if.valid && results_if.ready)
            begin
                if (awaited_parses.size() == 0)
                begin
                    $error("unexpected result beat: base_length %0d serial_number %0d",
                           results_if.base_length, results_if.serial_number);
                    error_count++;
                end
                else
                begin
                    if (results_if.base_length !== awaited_parses[0].base_length)
                    begin
                        $error("base_length: expected %0d, got %0d",
                               awaited_parses[0].base_length, results_if.base_length);
                        error_count++;
                    end
                    if (results_if.serial_number !== awaited_parses[0].serial_number)
                    begin
                        $error("serial_number: expected %0d, got %0d",
                               awaited_parses[0].serial_number, results_if.serial_number);
                        error_count++;
                    end
                    void'(awaited_parses.pop_front());
                end
            end
            results_if.ready <= !stall_on || ($urandom_range(99) >= STALL_PCT);
        end
    end

    // One byte beat, with optional idle cycles in front
    task send_byte(input logic [BYTE_W-1:0] b, input logic last);
        while (stall_on && $urandom_range(99) < STALL_PCT)
        begin
            name_stream_if.valid <= 1'b0;
            @(posedge clk);
        end
        name_stream_if.valid     <= 1'b1;
        name_stream_if.name_byte <= b;
        name_stream_if.is_last   <= last;
        do
            @(posedge clk);
        while (!name_stream_if.ready);
        parse_name_byte(b, last);
        bytes_sent++;
    endtask

    task send_name();
        foreach (name_buf[i])
            send_byte(name_buf[i], i == name_buf.size() - 1);
        name_buf.delete();
        names_sent++;
    endtask

    task send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            name_buf.push_back(s[i]);
        send_name();
    endtask

    // Decimal digits of v, optionally with a leading '0'
    task automatic append_decimal(input logic [63:0] v, input bit lead_zero);
        logic [BYTE_W-1:0] digits[$];
        logic [63:0]       rest;
        logic [3:0]        d;
        rest = v;
        do
        begin
            d = 4'(rest % 10);
            digits.push_front(CHAR_ZERO + d);
            rest = rest / 10;
        end
        while (rest != 0);
        if (lead_zero)
            name_buf.push_back(CHAR_ZERO);
        foreach (digits[i])
            name_buf.push_back(digits[i]);
    endtask

    function logic [BYTE_W-1:0] random_letter();
        random_letter = BYTE_W'($urandom_range(8'h61, 8'h7A));
    endfunction

    // Bytes weighted towards digits and underscores
    function logic [BYTE_W-1:0] noise_byte();
        int pick;
        pick = $urandom_range(99);
        if (pick < 30)
            noise_byte = BYTE_W'($urandom_range(CHAR_ZERO, CHAR_NINE));
        else if (pick < 50)
            noise_byte = CHAR_UNDERSCORE;
        else
            noise_byte = BYTE_W'($urandom_range(0, 255));
    endfunction

    // Stop sending and wait for every owed parse
    task drain_results();
        name_stream_if.valid <= 1'b0;
        while (awaited_parses.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Short names around the suffix rules, plus single-byte names at both byte extremes
    task test_short_names();
        send_text("ab_1");
        send_text("_12");   // underscore as first byte, minimum length
        send_text("_7");    // too short
        send_text("x_0");   // zero suffix
        send_text("x_07");  // leading zero
        send_text("123");   // digits only, no underscore
        send_text("a_");    // underscore, no digits
        name_buf.push_back(8'hFF);
        send_name();
        name_buf.push_back(8'h00);
        send_name();
    endtask

    // Byte count saturates at the maximum length
    task test_over_long_names();
        repeat (NAME_MAX_LEN + 4)
            name_buf.push_back(random_letter());
        name_buf.push_back(CHAR_UNDERSCORE);
        append_decimal(64'd5, 1'b0);
        send_name();
    endtask

    // Mostly prefix + "_N" names with edge-heavy values, the rest noise
    task test_random_names(input int byte_budget, input bit stalls);
        int                start;
        int                prefix_len;
        logic [63:0]       serial;
        logic [BYTE_W-1:0] b;
        start    = bytes_sent;
        stall_on = stalls;
        while (bytes_sent - start < byte_budget)
        begin
            if ($urandom_range(99) < 70)
            begin
                prefix_len = $urandom_range(0, 10);
                repeat (prefix_len)
                begin
                    b = ($urandom_range(99) < 60) ? random_letter()
                                                  : BYTE_W'($urandom_range(0, 255));
                    name_buf.push_back(b);
                end
                name_buf.push_back(CHAR_UNDERSCORE);
                case ($urandom_range(0, 10))
                    0:       serial = 64'd4294967295;
                    1:       serial = 64'd4294967296;
                    2:       serial = 64'd9999999999;
                    3:       serial = 64'd1000000000;
                    4:       serial = 64'd10000000000;
                    5:       serial = {$urandom, $urandom};
                    6:       serial = 64'($urandom_range(0, 9));
                    7:       serial = 64'($urandom_range(10, 99999));
                    default: serial = 64'($urandom);
                endcase
                append_decimal(serial, $urandom_range(99) < 10);
            end
            else
            begin
                repeat ($urandom_range(1, 12))
                    name_buf.push_back(noise_byte());
            end
            send_name();
        end
    endtask

    initial
    begin
        name_stream_if.valid     = 1'b0;
        name_stream_if.name_byte = '0;
        name_stream_if.is_last   = 1'b0;
        clear_parse();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_short_names();
        test_over_long_names();
        test_random_names(300, 1'b1);
        drain_results();
        // long stretch with both sides always ready
        test_random_names(300, 1'b0);
        test_random_names(300, 1'b1);
        drain_results();
        repeat (8) @(posedge clk);

        $display("Parsed %0d names in %0d byte beats, %0d with an accepted suffix;",
                 names_sent, bytes_sent, suffixes_found);
        $display("covered short, over-long, zero, leading-zero and overflowing suffixes.");
        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // Watchdog
    initial
    begin
        #2_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
